/* rtl/core/tked_pkg.sv */
// Shared types, constants and the sequence matcher for the terminal key escape decoder.
`timescale 1ns / 1ps

package tked_pkg;

   // Most results one input transfer can cause: ESC, three held bytes, one fresh byte.
   localparam int MaxResults = 5;
   localparam int CntWidth   = $clog2(MaxResults + 1);
   localparam int IdxWidth   = $clog2(MaxResults);

   // Byte values that steer decoding.
   localparam logic [7:0] ByteEsc     = 8'h1B;
   localparam logic [7:0] ByteLf      = 8'h0A;
   localparam logic [7:0] ByteDel     = 8'h7F;
   localparam logic [7:0] ByteBs      = 8'h08;
   localparam logic [7:0] ByteSs3     = 8'h4F;  // 'O'
   localparam logic [7:0] ByteCsi     = 8'h5B;  // '['
   localparam logic [7:0] ByteTilde   = 8'h7E;  // '~'

   // Input kinds.
   localparam logic KindByte = 1'b0;
   localparam logic KindIdle = 1'b1;

   // Dense key ids.
   localparam logic [4:0] KeyF1    = 5'd0;
   localparam logic [4:0] KeyF2    = 5'd1;
   localparam logic [4:0] KeyF3    = 5'd2;
   localparam logic [4:0] KeyF4    = 5'd3;
   localparam logic [4:0] KeyF5    = 5'd4;
   localparam logic [4:0] KeyF6    = 5'd5;
   localparam logic [4:0] KeyF7    = 5'd6;
   localparam logic [4:0] KeyF8    = 5'd7;
   localparam logic [4:0] KeyF9    = 5'd8;
   localparam logic [4:0] KeyF12   = 5'd9;
   localparam logic [4:0] KeyIns   = 5'd10;
   localparam logic [4:0] KeyDel   = 5'd11;
   localparam logic [4:0] KeyPgUp  = 5'd12;
   localparam logic [4:0] KeyPgDn  = 5'd13;
   localparam logic [4:0] KeyUp    = 5'd14;
   localparam logic [4:0] KeyDown  = 5'd15;
   localparam logic [4:0] KeyRight = 5'd16;
   localparam logic [4:0] KeyLeft  = 5'd17;
   localparam logic [4:0] KeyEnd   = 5'd18;
   localparam logic [4:0] KeyHome  = 5'd19;
   localparam logic [4:0] KeyEnter = 5'd20;

   // One result item.
   typedef struct packed {
      logic       is_key;
      logic [4:0] key_id;
      logic [7:0] out_byte;
   } res_type;

   // All results of one input transfer, handed from decoder to output stage.
   typedef struct packed {
      res_type [MaxResults-1:0] ent;
      logic [CntWidth-1:0]      cnt;
   } list_type;

   // Outcome of matching the held prefix plus one new byte.
   typedef struct packed {
      logic       hit;
      logic       part;
      logic [4:0] key;
   } match_type;

   function automatic res_type make_byte(logic [7:0] b);
      res_type r;
      r.is_key   = 1'b0;
      r.key_id   = 5'd0;
      r.out_byte = b;
      return r;
   endfunction

   function automatic res_type make_key(logic [4:0] k);
      res_type r;
      r.is_key   = 1'b1;
      r.key_id   = k;
      r.out_byte = 8'h00;
      return r;
   endfunction

   // Match the candidate (held bytes, then b) against all key sequences after ESC.
   function automatic match_type classify(logic [1:0] pcnt, logic [7:0] p0,
                                          logic [7:0] p1, logic [7:0] p2,
                                          logic [7:0] b);
      match_type m;
      m.hit  = 1'b0;
      m.part = 1'b0;
      m.key  = 5'd0;
      case (pcnt)
         2'd0: begin
            m.part = (b == ByteSs3) || (b == ByteCsi);
         end
         2'd1: begin
            if (p0 == ByteSs3) begin
               m.hit = 1'b1;
               case (b)
                  "P":     m.key = KeyF1;
                  "Q":     m.key = KeyF2;
                  "R":     m.key = KeyF3;
                  "S":     m.key = KeyF4;
                  default: m.hit = 1'b0;
               endcase
            end else if (p0 == ByteCsi) begin
               m.hit = 1'b1;
               case (b)
                  "A":     m.key = KeyUp;
                  "B":     m.key = KeyDown;
                  "C":     m.key = KeyRight;
                  "D":     m.key = KeyLeft;
                  "F":     m.key = KeyEnd;
                  "H":     m.key = KeyHome;
                  default: m.hit = 1'b0;
               endcase
               m.part = b inside {"1", "2", "3", "5", "6"};
            end
         end
         2'd2: begin
            if (p0 == ByteCsi) begin
               case (p1)
                  "1":     m.part = b inside {"5", "7", "8", "9"};
                  "2": begin
                     m.part = b inside {"0", "4"};
                     m.hit  = (b == ByteTilde);
                     m.key  = KeyIns;
                  end
                  "3": begin
                     m.hit = (b == ByteTilde);
                     m.key = KeyDel;
                  end
                  "5": begin
                     m.hit = (b == ByteTilde);
                     m.key = KeyPgUp;
                  end
                  "6": begin
                     m.hit = (b == ByteTilde);
                     m.key = KeyPgDn;
                  end
                  default: m.part = 1'b0;
               endcase
            end
         end
         default: begin
            if (p0 == ByteCsi && b == ByteTilde) begin
               m.hit = 1'b1;
               if (p1 == "1") begin
                  case (p2)
                     "5":     m.key = KeyF5;
                     "7":     m.key = KeyF6;
                     "8":     m.key = KeyF7;
                     "9":     m.key = KeyF8;
                     default: m.hit = 1'b0;
                  endcase
               end else if (p1 == "2") begin
                  case (p2)
                     "0":     m.key = KeyF9;
                     "4":     m.key = KeyF12;
                     default: m.hit = 1'b0;
                  endcase
               end else begin
                  m.hit = 1'b0;
               end
            end
         end
      endcase
      return m;
   endfunction

endpackage

/* rtl/core/tked_decode.sv */
// Sequence state and per-transfer result list builder for the escape decoder.
`timescale 1ns / 1ps

module tked_decode
   import tked_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic [7:0] data_byte,
   output list_type   list
);

   logic       pend_ff;
   logic       pend_in;
   logic [1:0] pcnt_ff;
   logic [1:0] pcnt_in;
   logic [7:0] pbyte_ff [3];

   match_type           cls;
   logic                is_esc;
   logic                store;
   logic                flush;
   logic                use_fresh;
   logic                key_hit;
   res_type             fresh_res;
   logic [CntWidth-1:0] flush_n;

   assign cls    = classify(pcnt_ff, pbyte_ff[0], pbyte_ff[1], pbyte_ff[2], data_byte);
   assign is_esc = (data_byte == ByteEsc);

   // Result for a byte seen outside a sequence.
   always_comb begin
      if (data_byte == ByteLf) begin
         fresh_res = make_key(KeyEnter);
      end else if (data_byte == ByteDel) begin
         fresh_res = make_byte(ByteBs);
      end else begin
         fresh_res = make_byte(data_byte);
      end
   end

   // Decide what this transfer does to the open sequence.
   always_comb begin
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      store     = 1'b0;
      flush     = 1'b0;
      use_fresh = 1'b0;
      key_hit   = 1'b0;
      if (kind == KindIdle) begin
         if (pend_ff) begin
            flush   = 1'b1;
            pend_in = 1'b0;
            pcnt_in = 2'd0;
         end
      end else if (!pend_ff) begin
         use_fresh = 1'b1;
         pend_in   = is_esc;
         pcnt_in   = 2'd0;
      end else if (cls.hit) begin
         key_hit = 1'b1;
         pend_in = 1'b0;
         pcnt_in = 2'd0;
      end else if (cls.part && pcnt_ff != 2'd3) begin
         store   = 1'b1;
         pcnt_in = pcnt_ff + 2'd1;
      end else begin
         flush     = 1'b1;
         use_fresh = 1'b1;
         pend_in   = is_esc;
         pcnt_in   = 2'd0;
      end
   end

   // Build the ordered result list: flushed ESC and prefix first, then the fresh byte.
   assign flush_n = flush ? CntWidth'(pcnt_ff) + CntWidth'(1) : '0;

   always_comb begin
      for (int i = 0; i < MaxResults; i++) begin
         list.ent[i] = fresh_res;
      end
      if (key_hit) begin
         list.ent[0] = make_key(cls.key);
      end else if (flush) begin
         list.ent[0] = make_byte(ByteEsc);
         for (int i = 1; i <= 3; i++) begin
            if (pcnt_ff >= 2'(i)) begin
               list.ent[i] = make_byte(pbyte_ff[i-1]);
            end
         end
      end
      if (key_hit) begin
         list.cnt = CntWidth'(1);
      end else begin
         list.cnt = flush_n + CntWidth'(use_fresh && !is_esc);
      end
   end

   // Sequence state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         pcnt_ff <= 2'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
      end
   end

   // Held prefix bytes; only entries below the count are ever read.
   always_ff @(posedge clock) begin
      if (accept && store) begin
         pbyte_ff[pcnt_ff] <= data_byte;
      end
   end

   // Held bytes exist only inside an open sequence.
   assert property (@(posedge clock) disable iff (reset) (pcnt_ff != 2'd0) |-> pend_ff)
      else $error("prefix count nonzero without an open sequence");

endmodule

/* rtl/core/tked_drain.sv */
// Result list register that hands out one result per cycle unless stalled.
`timescale 1ns / 1ps

module tked_drain
   import tked_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  list_type   list,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_key,
   output logic [4:0] rsp_key_id,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   res_type [MaxResults-1:0] ent_ff;
   logic [CntWidth-1:0]      cnt_ff;
   logic [IdxWidth-1:0]      idx_ff;

   logic    busy;
   logic    take;
   logic    at_last;
   res_type cur;

   assign busy    = (cnt_ff != '0);
   assign take    = busy && !rsp_stall;
   assign at_last = (CntWidth'(idx_ff) + CntWidth'(1) == cnt_ff);
   assign free    = !busy || (take && at_last);

   // Present the current entry.
   assign cur          = ent_ff[idx_ff];
   assign rsp_valid    = busy;
   assign rsp_is_key   = cur.is_key;
   assign rsp_key_id   = cur.key_id;
   assign rsp_out_byte = cur.out_byte;
   assign rsp_last     = at_last;

   // Control: load a new list or step through the current one.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (load && list.cnt != '0) begin
         cnt_ff <= list.cnt;
         idx_ff <= '0;
      end else if (take && at_last) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + IdxWidth'(1);
      end
   end

   // Payload of the list.
   always_ff @(posedge clock) begin
      if (load && list.cnt != '0) begin
         ent_ff <= list.ent;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
                    cnt_ff <= CntWidth'(MaxResults))
      else $error("result count out of range");

   assert property (@(posedge clock) disable iff (reset)
                    busy |-> (CntWidth'(idx_ff) < cnt_ff))
      else $error("result index beyond result count");

   assert property (@(posedge clock) disable iff (reset)
                    (load && list.cnt != '0) |-> free)
      else $error("new result list loaded over undelivered results");

   assert property (@(posedge clock) reset |=> (cnt_ff == '0))
      else $error("result list not empty after reset");

endmodule

/* rtl/core/terminal_key_escape_decoder_top.sv */
// Top level of the terminal key escape decoder.
//
// Input channel (req_*): one transfer carries either a received byte
// (req_kind = 0, req_data_byte) or an idle mark (req_kind = 1). Result
// channel (rsp_*): each transfer is a key id (rsp_is_key = 1) or a plain byte,
// and rsp_last marks the final result caused by one input transfer.
// Each input transfer yields zero to five results. They are built in the same
// cycle the input is taken and appear on the result channel in the next cycle,
// then drain one per cycle unless stalled. A new input is taken in the cycle
// the final result of the previous one is taken, so unstalled items with one
// result flow at one per cycle; with several results, new input waits for the
// final one to be taken. The single result list register sets this rate.
// Reset is synchronous: it closes any open sequence and empties the result
// list. While the receiver stalls, the current result holds and req_stall
// rises once the list cannot be freed in this cycle.
`timescale 1ns / 1ps

module terminal_key_escape_decoder_top
   import tked_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_key,
   output logic [4:0] rsp_key_id,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic     accept;
   logic     free;
   list_type list;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   // Sequence tracking and result list construction.
   tked_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .list      (list)
   );

   // Result list register and output serialization.
   tked_drain u_drain (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .list         (list),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_key   (rsp_is_key),
      .rsp_key_id   (rsp_key_id),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
